// File: design/ook_pulse_manchester_decoder_core_defines.svh
// Assertion helpers for the pulse decoder core.
`ifndef OOK_PULSE_MANCHESTER_DECODER_CORE_DEFINES_SVH
`define OOK_PULSE_MANCHESTER_DECODER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define OOK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define OOK_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ookmd_pkg.sv
package ookmd_pkg;

  localparam int PW_W             = 16;
  localparam int CNTW             = $clog2(PW_W);
  localparam int BUFFER_BYTES_DEF = 16;
  localparam int MAX_RUN          = 16;
  localparam int RUN_W            = $clog2(MAX_RUN + 1);

  // Threshold slots of the serial comparator
  localparam int NUM_TH     = 6;
  localparam int TH_MIN_V2  = 0;
  localparam int TH_MIN_V3  = 1;
  localparam int TH_LONG_V2 = 2;
  localparam int TH_LONG_V3 = 3;
  localparam int TH_MAX     = 4;
  localparam int TH_GAP     = 5;

  localparam logic [PW_W-1:0] THRESH [NUM_TH] = '{
    16'd150, 16'd200, 16'd600, 16'd675, 16'd1200, 16'd2500
  };

  localparam logic [7:0] PRE_V2   = 8'd24;
  localparam logic [7:0] PRE_V3   = 8'd32;
  localparam logic [7:0] BITS_V2  = 8'd160;
  localparam logic [7:0] BITS_V3  = 8'd80;
  localparam logic [7:0] GAP_HELD = 8'd8;
  localparam logic [7:0] CNT_SAT  = 8'hFF;

  typedef enum logic [1:0] {
    STATUS_BUSY   = 2'd0,
    STATUS_BYTE   = 2'd1,
    STATUS_REJECT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HALF = 2'd1,
    PH_SYNC = 2'd2
  } phase_e;

  // Number of complete bytes held for a given bit count.
  function automatic logic [7:0] held_of(input logic m, input logic [7:0] b);
    return m ? (b >> 3) : (b >> 4);
  endfunction

endpackage

// File: design/ook_pulse_manchester_decoder_core.sv
// Pulse-width decoder for on-off-keyed Manchester frames. Each accepted pulse width is
// compared against the timing thresholds by a bit-serial comparator, MSB first, one bit
// per cycle; the pulse is loaded, compared in ST_SCAN, decoded in ST_DECIDE and then
// registered to the output from ST_REPORT or ST_FRAME. A pulse that completes a frame
// returns one result per held byte, one byte per cycle while the output is not stalled,
// for up to 10 held bytes. Results carry status (0 in progress, 1 frame byte, 2 pulse
// rejected), frame_byte and last; last marks the final result of a pulse.
// Writing the mode register (0: version two timing with every other bit kept, 1: version
// three timing) clears the decoder. No clearing pass after reset is needed.
`include "ook_pulse_manchester_decoder_core_defines.svh"

module ook_pulse_manchester_decoder_core #(
  parameter int BUFFER_BYTES = ookmd_pkg::BUFFER_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ookmd_pkg::PW_W-1:0] pulse_width_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_mode_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [7:0]                 frame_byte_o,
  output logic                       last_o
);
  import ookmd_pkg::*;

  localparam int         IDXW    = $clog2(BUFFER_BYTES);
  localparam logic [7:0] BUF_LIM = 8'(BUFFER_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_REPORT,
    ST_FRAME
  } state_e;

  state_e            state_q;
  logic [PW_W-1:0]   pw_q;
  logic [CNTW-1:0]   cnt_q;
  logic [NUM_TH-1:0] gt_q, lt_q, gt_d, lt_d, th_bits, ge;
  logic [CNTW-1:0]   bit_pos;

  logic              mode_q;
  phase_e            phase_q, ph_n;
  logic [7:0]        lvl_q, lvl_n;
  logic [7:0]        bits_q, bits_n;
  logic [7:0]        cur_q, cur_n;
  logic [7:0]        buf_q [BUFFER_BYTES];

  status_e           res_q;
  logic [RUN_W-1:0]  run_q, emit_k_q, run_n;

  logic              out_valid_q, out_last_q;
  status_e           out_status_q;
  logic [7:0]        out_byte_q;

  logic [7:0]        held_q, held_n, held_inc, bits_inc, cur_k, wr_byte;
  logic [IDXW-1:0]   wr_idx;
  logic              wr_en, reject, gap_done, clr, frame_done;
  logic              in_range, lng, sym_en, sym_val, sym_base, sym_bit, keep;
  logic              out_free, emit_last, out_load;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign cfg_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign frame_byte_o = out_byte_q;
  assign last_o       = out_last_q;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = out_free && (state_q == ST_REPORT || state_q == ST_FRAME);
  assign emit_last = (emit_k_q == run_q - RUN_W'(1));
  assign held_q    = held_of(mode_q, bits_q);
  assign ge        = ~lt_q;

  // One magnitude bit per cycle against every threshold
  always_comb begin
    bit_pos = CNTW'(PW_W - 1) - cnt_q;
    for (int i = 0; i < NUM_TH; i++) begin
      th_bits[i] = THRESH[i][bit_pos];
      gt_d[i] = gt_q[i] | (!lt_q[i] & pw_q[PW_W-1] & !th_bits[i]);
      lt_d[i] = lt_q[i] | (!gt_q[i] & !pw_q[PW_W-1] & th_bits[i]);
    end
  end

  always_comb begin
    ph_n     = phase_q;
    lvl_n    = lvl_q;
    bits_n   = bits_q;
    cur_n    = cur_q;
    wr_en    = 1'b0;
    wr_idx   = held_q[IDXW-1:0];
    wr_byte  = cur_q;
    reject   = 1'b0;
    gap_done = 1'b0;
    clr      = 1'b0;
    sym_en   = 1'b0;
    sym_val  = 1'b0;
    sym_base = lvl_q[0];
    in_range = mode_q ? (ge[TH_MIN_V3] & ~ge[TH_MAX]) : (ge[TH_MIN_V2] & ~ge[TH_MAX]);
    lng      = mode_q ? ge[TH_LONG_V3] : ge[TH_LONG_V2];

    if (!in_range) begin
      if (!mode_q && ge[TH_GAP] && held_q >= GAP_HELD) begin
        gap_done = 1'b1;
      end else begin
        reject = 1'b1;
      end
    end else begin
      case (phase_q)
        PH_HUNT: begin
          // preamble is long pulses in version two, short ones in version three
          if (lng == !mode_q) begin
            if (lvl_q != CNT_SAT) begin
              lvl_n = lvl_q + 8'd1;
            end
          end else if (lvl_q >= (mode_q ? PRE_V3 : PRE_V2)) begin
            if (mode_q) begin
              sym_en   = 1'b1;
              sym_val  = 1'b1;
              sym_base = 1'b1;
            end else begin
              lvl_n = '0;
              ph_n  = PH_HALF;
            end
          end else begin
            reject = 1'b1;
          end
        end
        PH_SYNC: begin
          if (!lng) begin
            ph_n = PH_HALF;
          end else begin
            sym_en  = 1'b1;
            sym_val = 1'b1;
          end
        end
        PH_HALF: begin
          if (!lng) begin
            sym_en = 1'b1;
          end else begin
            reject = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    sym_bit  = sym_base ^ sym_val;
    keep     = mode_q | ~bits_q[0];
    cur_k    = keep ? {sym_bit, cur_q[7:1]} : cur_q;
    bits_inc = bits_q + 8'd1;
    held_inc = held_of(mode_q, bits_inc);

    if (sym_en) begin
      if (bits_q == CNT_SAT || held_inc >= BUF_LIM) begin
        // drop the frame silently on overflow
        clr    = 1'b1;
        ph_n   = PH_HUNT;
        lvl_n  = '0;
        bits_n = '0;
        cur_n  = '0;
      end else begin
        ph_n   = PH_SYNC;
        lvl_n  = {7'd0, sym_bit};
        bits_n = bits_inc;
        if (held_inc != held_q) begin
          wr_en   = 1'b1;
          wr_byte = cur_k;
          cur_n   = '0;
        end else begin
          cur_n = cur_k;
        end
      end
    end

    held_n     = held_of(mode_q, bits_n);
    frame_done = gap_done
               | (!reject && !clr && bits_n == (mode_q ? BITS_V3 : BITS_V2));
    run_n      = (held_n >= 8'(MAX_RUN)) ? RUN_W'(MAX_RUN) : held_n[RUN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pw_q         <= '0;
      cnt_q        <= '0;
      gt_q         <= '0;
      lt_q         <= '0;
      mode_q       <= 1'b0;
      phase_q      <= PH_HUNT;
      lvl_q        <= '0;
      bits_q       <= '0;
      cur_q        <= '0;
      res_q        <= STATUS_BUSY;
      run_q        <= '0;
      emit_k_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_BUSY;
      out_byte_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cfg_valid_i) begin
            mode_q  <= cfg_mode_i;
            phase_q <= PH_HUNT;
            lvl_q   <= '0;
            bits_q  <= '0;
            cur_q   <= '0;
          end
          if (in_valid_i) begin
            pw_q    <= pulse_width_i;
            cnt_q   <= '0;
            gt_q    <= '0;
            lt_q    <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pw_q  <= pw_q << 1;
          gt_q  <= gt_d;
          lt_q  <= lt_d;
          cnt_q <= cnt_q + CNTW'(1);
          if (cnt_q == CNTW'(PW_W - 1)) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          res_q <= reject ? STATUS_REJECT : STATUS_BUSY;
          if (reject || (frame_done && run_n == '0)) begin
            phase_q <= PH_HUNT;
            lvl_q   <= '0;
            bits_q  <= '0;
            cur_q   <= '0;
            state_q <= ST_REPORT;
          end else begin
            phase_q <= ph_n;
            lvl_q   <= lvl_n;
            bits_q  <= bits_n;
            cur_q   <= cur_n;
            if (frame_done) begin
              run_q    <= run_n;
              emit_k_q <= '0;
              state_q  <= ST_FRAME;
            end else begin
              state_q <= ST_REPORT;
            end
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_q;
            out_byte_q   <= '0;
            out_last_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        ST_FRAME: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= STATUS_BYTE;
            out_byte_q   <= buf_q[0];
            out_last_q   <= emit_last;
            emit_k_q     <= emit_k_q + RUN_W'(1);
            if (emit_last) begin
              phase_q <= PH_HUNT;
              lvl_q   <= '0;
              bits_q  <= '0;
              cur_q   <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Completed bytes land at their index; a frame drains them from the head
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECIDE && wr_en) begin
      buf_q[wr_idx] <= wr_byte;
    end else if (state_q == ST_FRAME && out_free) begin
      for (int i = 0; i < BUFFER_BYTES - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
      buf_q[BUFFER_BYTES-1] <= '0;
    end
  end

  `OOK_ASSERT(a_held_bound, held_q < BUF_LIM, "held byte count reached buffer size")
  `OOK_ASSERT(a_emit_in_run, state_q == ST_FRAME |-> emit_k_q < run_q, "emit index past run")
  `OOK_ASSERT(a_single_last, out_valid_o && status_o != STATUS_BYTE |-> last_o && frame_byte_o == 8'd0, "non-byte result malformed")
  `OOK_ASSERT_NEXT(a_reject_clears, state_q == ST_DECIDE && reject, bits_q == 8'd0 && state_q == ST_REPORT, "reject did not clear decoder")

endmodule
